>>> rtl/msalu_pkg.sv
// Shared constants, codes and controller/datapath interface types of the multiword ALU.
package msalu_pkg;

  localparam int unsigned WORD_COUNT = 20;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SH_W       = 5;
  localparam int unsigned MAG_W      = WORD_COUNT * WORD_W;
  localparam int unsigned WK_W       = $clog2(WORD_COUNT);
  localparam int unsigned IDX_W      = $clog2(2 * WORD_COUNT);
  localparam int unsigned LEN_W      = $clog2(WORD_COUNT + 1);
  localparam int unsigned BIT_W      = $clog2(MAG_W);
  localparam int unsigned SIDX_W     = $clog2(4 * WORD_COUNT) + 1;
  localparam int unsigned ACC_W      = 2 * WORD_W + 8;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_EXEC   = 2'd2;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_QUO = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;
  localparam logic [2:0] OP_SHL = 3'd5;
  localparam logic [2:0] OP_SHR = 3'd6;

  typedef logic [WORD_COUNT-1:0][WORD_W-1:0] mag_t;

  typedef struct packed {
    logic             load_a;
    logic             load_b;
    logic             clear;
    logic [2:0]       op;
    logic             carry_clr;
    logic             as_step;
    logic             as_swap;
    logic             as_fin;
    logic             mul_issue;
    logic             mul_last;
    logic             mul_fin;
    logic             div_step;
    logic             rem_copy;
    logic             shl_step;
    logic             shr_step;
    logic             len_cap;
    logic             emit;
    logic             emit_last;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] i;
    logic [BIT_W-1:0] bit_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic             same_sign;
    logic             carry;
    logic             b_zero;
    logic             cnt_big;
    logic [LEN_W-1:0] len;
  } dp_stat_t;

endpackage

>>> rtl/msalu_dp.sv
// Datapath of the multiword ALU: operand words, result words, multiplier, divider and shifter.
module msalu_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  msalu_pkg::dp_cmd_t       cmd_i,
  input  logic [4:0]               word_index_i,
  input  logic [31:0]              word_value_i,
  input  logic                     sign_i,
  output msalu_pkg::dp_stat_t      stat_o,
  output logic                     strobe_o,
  output logic [4:0]               out_index_o,
  output logic [31:0]              out_word_o,
  output logic                     result_sign_o,
  output logic [4:0]               result_length_o,
  output logic                     last_o,
  output logic                     overflow_o,
  output logic                     divide_by_zero_o
);

  msalu_pkg::mag_t a_q, a_d, b_q, b_d, res_q, res_d;
  logic a_neg_q, a_neg_d, b_neg_q, b_neg_d;
  logic [2:0] op_q, op_d;
  logic [msalu_pkg::MAG_W-1:0] rem_q, rem_d;
  logic carry_q, carry_d;
  logic [msalu_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [2*msalu_pkg::WORD_W-1:0] p_q, p_d;
  logic pv_q, pv_d, plast_q, plast_d;
  logic [msalu_pkg::IDX_W-1:0] pcol_q, pcol_d;
  logic [msalu_pkg::WORD_W-1:0] prev_q, prev_d;
  logic neg_q, neg_d, ovf_q, ovf_d, dz_q, dz_d;
  logic [msalu_pkg::LEN_W-1:0] len_q, len_d;
  logic strobe_q, strobe_d, last_q, last_d;
  logic [4:0] oidx_q, oidx_d, olen_q, olen_d;
  logic [31:0] oword_q, oword_d;
  logic osign_q, osign_d, oovf_q, oovf_d, odz_q, odz_d;

  logic bneg, same;
  logic b_zero, cnt_big;
  logic [msalu_pkg::WORD_W-1:0] cnt;
  logic [msalu_pkg::BIT_W-msalu_pkg::SH_W-1:0] ws;
  logic [msalu_pkg::SH_W-1:0] bs;
  logic [msalu_pkg::SH_W:0] back_amt;
  logic [msalu_pkg::WK_W-1:0] kw, a_addr, b_addr;
  logic [msalu_pkg::IDX_W-1:0] j_idx;
  logic signed [msalu_pkg::SIDX_W-1:0] s_val;
  logic in_rng;
  logic [msalu_pkg::WORD_W-1:0] a_rd, b_rd, x_op, y_op, cur, w_l, w_r;
  logic [msalu_pkg::WORD_W:0] as_sum;
  logic [msalu_pkg::ACC_W-1:0] sum;
  logic abit, ge;
  logic [msalu_pkg::MAG_W:0] r_sh;
  logic [msalu_pkg::MAG_W+1:0] diff;
  logic [msalu_pkg::MAG_W-1:0] res_flat, b_flat;
  logic [msalu_pkg::LEN_W-1:0] len_c;

  assign res_flat = res_q;
  assign b_flat   = b_q;
  assign bneg     = b_neg_q ^ (op_q == msalu_pkg::OP_SUB);
  assign same     = (a_neg_q == bneg);
  assign b_zero   = (b_q == '0);
  assign cnt      = b_q[0];
  assign cnt_big  = (cnt >= 32'(msalu_pkg::MAG_W));
  assign ws       = cnt[msalu_pkg::BIT_W-1:msalu_pkg::SH_W];
  assign bs       = cnt[msalu_pkg::SH_W-1:0];
  assign back_amt = (msalu_pkg::SH_W+1)'(msalu_pkg::WORD_W) - {1'b0, bs};
  assign kw       = cmd_i.k[msalu_pkg::WK_W-1:0];
  assign j_idx    = cmd_i.k - cmd_i.i;

  // Source word index of a shift: output word plus or minus the word offset
  always_comb begin
    if (cmd_i.shl_step) begin
      s_val = $signed(msalu_pkg::SIDX_W'(cmd_i.k)) - $signed(msalu_pkg::SIDX_W'(ws));
    end else begin
      s_val = $signed(msalu_pkg::SIDX_W'(cmd_i.k)) + $signed(msalu_pkg::SIDX_W'(ws));
    end
    in_rng = (s_val >= 0) && (s_val < $signed(msalu_pkg::SIDX_W'(msalu_pkg::WORD_COUNT)));
  end

  // One read address per operand
  always_comb begin
    if (cmd_i.mul_issue) begin
      a_addr = cmd_i.i[msalu_pkg::WK_W-1:0];
    end else if (cmd_i.div_step) begin
      a_addr = msalu_pkg::WK_W'(cmd_i.bit_idx[msalu_pkg::BIT_W-1:msalu_pkg::SH_W]);
    end else if (cmd_i.shl_step || cmd_i.shr_step) begin
      a_addr = s_val[msalu_pkg::WK_W-1:0];
    end else begin
      a_addr = kw;
    end
    b_addr = cmd_i.mul_issue ? j_idx[msalu_pkg::WK_W-1:0] : kw;
  end

  assign a_rd = a_q[a_addr];
  assign b_rd = b_q[b_addr];
  assign cur  = in_rng ? a_rd : '0;
  assign x_op = cmd_i.as_swap ? b_rd : a_rd;
  assign y_op = cmd_i.as_swap ? a_rd : b_rd;

  always_comb begin
    if (same) begin
      as_sum = {1'b0, x_op} + {1'b0, y_op} + {32'd0, carry_q};
    end else begin
      as_sum = {1'b0, x_op} - {1'b0, y_op} - {32'd0, carry_q};
    end
  end

  assign w_l = (cur << bs) | ((bs != '0) ? (prev_q >> back_amt) : '0);
  assign w_r = (cur >> bs) | ((bs != '0) ? (prev_q << back_amt) : '0);

  assign sum  = acc_q + msalu_pkg::ACC_W'(p_q);
  assign abit = a_rd[cmd_i.bit_idx[msalu_pkg::SH_W-1:0]];
  assign r_sh = {rem_q, abit};
  assign diff = {1'b0, r_sh} - {2'b00, b_flat};
  assign ge   = ~diff[msalu_pkg::MAG_W+1];

  always_comb begin
    len_c = '0;
    for (int w = 0; w < msalu_pkg::WORD_COUNT; w++) begin
      if (res_q[w] != '0) len_c = msalu_pkg::LEN_W'(w + 1);
    end
  end

  always_comb begin
    a_d = a_q; b_d = b_q; a_neg_d = a_neg_q; b_neg_d = b_neg_q;
    op_d = op_q; res_d = res_q; rem_d = rem_q; carry_d = carry_q;
    acc_d = acc_q; p_d = p_q; pv_d = cmd_i.mul_issue; plast_d = plast_q; pcol_d = pcol_q;
    prev_d = prev_q; neg_d = neg_q; ovf_d = ovf_q; dz_d = dz_q; len_d = len_q;
    strobe_d = cmd_i.emit; last_d = last_q; oidx_d = oidx_q; olen_d = olen_q;
    oword_d = oword_q; osign_d = osign_q; oovf_d = oovf_q; odz_d = odz_q;

    if (cmd_i.load_a) begin
      if (32'(word_index_i) < msalu_pkg::WORD_COUNT) begin
        a_d[msalu_pkg::WK_W'(word_index_i)] = word_value_i;
      end
      a_neg_d = sign_i;
    end
    if (cmd_i.load_b) begin
      if (32'(word_index_i) < msalu_pkg::WORD_COUNT) begin
        b_d[msalu_pkg::WK_W'(word_index_i)] = word_value_i;
      end
      b_neg_d = sign_i;
    end

    if (cmd_i.clear) begin
      op_d    = cmd_i.op;
      res_d   = '0;
      rem_d   = '0;
      carry_d = 1'b0;
      acc_d   = '0;
      prev_d  = '0;
      ovf_d   = (cmd_i.op == msalu_pkg::OP_SHL) && cnt_big && (a_q != '0);
      dz_d    = ((cmd_i.op == msalu_pkg::OP_QUO) || (cmd_i.op == msalu_pkg::OP_REM)) && b_zero;
      if ((cmd_i.op == msalu_pkg::OP_MUL) || (cmd_i.op == msalu_pkg::OP_QUO)) begin
        neg_d = a_neg_q ^ b_neg_q;
      end else begin
        neg_d = a_neg_q;
      end
    end

    if (cmd_i.carry_clr) carry_d = 1'b0;

    if (cmd_i.as_step) begin
      res_d[kw] = as_sum[msalu_pkg::WORD_W-1:0];
      carry_d   = as_sum[msalu_pkg::WORD_W];
    end
    if (cmd_i.as_fin) begin
      neg_d = (same || cmd_i.as_swap) ? bneg : a_neg_q;
      ovf_d = same & carry_q;
    end

    // Product stage is registered and feeds the column accumulator in the cycle after issue
    if (cmd_i.mul_issue) begin
      p_d     = {32'd0, a_rd} * {32'd0, b_rd};
      plast_d = cmd_i.mul_last;
      pcol_d  = cmd_i.k;
    end
    if (pv_q) begin
      if (plast_q) begin
        if (32'(pcol_q) < msalu_pkg::WORD_COUNT) begin
          res_d[pcol_q[msalu_pkg::WK_W-1:0]] = sum[msalu_pkg::WORD_W-1:0];
        end else if (sum[msalu_pkg::WORD_W-1:0] != '0) begin
          ovf_d = 1'b1;
        end
        acc_d = sum >> msalu_pkg::WORD_W;
      end else begin
        acc_d = sum;
      end
    end
    if (cmd_i.mul_fin && (acc_q != '0)) ovf_d = 1'b1;

    if (cmd_i.div_step) begin
      rem_d = ge ? diff[msalu_pkg::MAG_W-1:0] : r_sh[msalu_pkg::MAG_W-1:0];
      res_d = {res_flat[msalu_pkg::MAG_W-2:0], ge};
    end
    if (cmd_i.rem_copy) res_d = rem_q;

    if (cmd_i.shl_step) begin
      if (32'(cmd_i.k) < msalu_pkg::WORD_COUNT) begin
        res_d[kw] = w_l;
      end else if (w_l != '0) begin
        ovf_d = 1'b1;
      end
      prev_d = cur;
    end
    if (cmd_i.shr_step) begin
      res_d[kw] = w_r;
      prev_d    = cur;
    end

    if (cmd_i.len_cap) begin
      len_d = len_c;
      if (len_c == '0) neg_d = 1'b0;
    end

    if (cmd_i.emit) begin
      last_d  = cmd_i.emit_last;
      oidx_d  = 5'(cmd_i.k);
      oword_d = res_q[kw];
      olen_d  = 5'(len_q);
      osign_d = neg_q;
      oovf_d  = ovf_q;
      odz_d   = dz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; b_q <= '0; a_neg_q <= 1'b0; b_neg_q <= 1'b0;
      op_q <= '0; res_q <= '0; rem_q <= '0; carry_q <= 1'b0;
      acc_q <= '0; p_q <= '0; pv_q <= 1'b0; plast_q <= 1'b0; pcol_q <= '0;
      prev_q <= '0; neg_q <= 1'b0; ovf_q <= 1'b0; dz_q <= 1'b0; len_q <= '0;
      strobe_q <= 1'b0; last_q <= 1'b0; oidx_q <= '0; olen_q <= '0;
      oword_q <= '0; osign_q <= 1'b0; oovf_q <= 1'b0; odz_q <= 1'b0;
    end else begin
      a_q <= a_d; b_q <= b_d; a_neg_q <= a_neg_d; b_neg_q <= b_neg_d;
      op_q <= op_d; res_q <= res_d; rem_q <= rem_d; carry_q <= carry_d;
      acc_q <= acc_d; p_q <= p_d; pv_q <= pv_d; plast_q <= plast_d; pcol_q <= pcol_d;
      prev_q <= prev_d; neg_q <= neg_d; ovf_q <= ovf_d; dz_q <= dz_d; len_q <= len_d;
      strobe_q <= strobe_d; last_q <= last_d; oidx_q <= oidx_d; olen_q <= olen_d;
      oword_q <= oword_d; osign_q <= osign_d; oovf_q <= oovf_d; odz_q <= odz_d;
    end
  end

  assign stat_o.same_sign = same;
  assign stat_o.carry     = carry_q;
  assign stat_o.b_zero    = b_zero;
  assign stat_o.cnt_big   = cnt_big;
  assign stat_o.len       = len_q;

  assign strobe_o         = strobe_q;
  assign out_index_o      = oidx_q;
  assign out_word_o       = oword_q;
  assign result_sign_o    = osign_q;
  assign result_length_o  = olen_q;
  assign last_o           = last_q;
  assign overflow_o       = oovf_q;
  assign divide_by_zero_o = odz_q;

endmodule

>>> rtl/msalu_ctrl.sv
// Controller of the multiword ALU: sequences loads, operation passes and result emission.
module msalu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          cmd_i,
  input  logic [2:0]          op_i,
  input  msalu_pkg::dp_stat_t stat_i,
  output msalu_pkg::dp_cmd_t  dp_cmd_o,
  output logic                busy
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_AS        = 4'd1;
  localparam logic [3:0] S_AS_CHK    = 4'd2;
  localparam logic [3:0] S_MUL       = 4'd3;
  localparam logic [3:0] S_MUL_DRAIN = 4'd4;
  localparam logic [3:0] S_MUL_FIN   = 4'd5;
  localparam logic [3:0] S_DIV       = 4'd6;
  localparam logic [3:0] S_REM       = 4'd7;
  localparam logic [3:0] S_SHL       = 4'd8;
  localparam logic [3:0] S_SHR       = 4'd9;
  localparam logic [3:0] S_LEN       = 4'd10;
  localparam logic [3:0] S_EMIT      = 4'd11;

  logic [3:0] state_q, state_d;
  logic [2:0] op_q, op_d;
  logic [msalu_pkg::IDX_W-1:0] k_q, k_d, i_q, i_d, hi, lo_next;
  logic [msalu_pkg::BIT_W-1:0] bit_q, bit_d;
  logic swap_q, swap_d;
  logic [msalu_pkg::LEN_W-1:0] n_words;

  assign busy = (state_q != S_IDLE);

  // Row range of the current product column
  assign hi = (32'(k_q) < msalu_pkg::WORD_COUNT) ? k_q :
              msalu_pkg::IDX_W'(msalu_pkg::WORD_COUNT - 1);
  assign lo_next = (32'(k_q) + 1 >= msalu_pkg::WORD_COUNT) ?
                   msalu_pkg::IDX_W'(32'(k_q) + 2 - msalu_pkg::WORD_COUNT) : '0;
  assign n_words = (stat_i.len == '0) ? msalu_pkg::LEN_W'(1) : stat_i.len;

  always_comb begin
    state_d = state_q; op_d = op_q; k_d = k_q; i_d = i_q; bit_d = bit_q; swap_d = swap_q;
    dp_cmd_o         = '0;
    dp_cmd_o.op      = op_i;
    dp_cmd_o.k       = k_q;
    dp_cmd_o.i       = i_q;
    dp_cmd_o.bit_idx = bit_q;
    dp_cmd_o.as_swap = swap_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_i)
            msalu_pkg::CMD_LOAD_A: dp_cmd_o.load_a = 1'b1;
            msalu_pkg::CMD_LOAD_B: dp_cmd_o.load_b = 1'b1;
            msalu_pkg::CMD_EXEC: begin
              op_d   = op_i;
              k_d    = '0;
              i_d    = '0;
              swap_d = 1'b0;
              bit_d  = msalu_pkg::BIT_W'(msalu_pkg::MAG_W - 1);
              dp_cmd_o.clear = 1'b1;
              case (op_i)
                msalu_pkg::OP_ADD, msalu_pkg::OP_SUB: state_d = S_AS;
                msalu_pkg::OP_MUL: state_d = S_MUL;
                msalu_pkg::OP_QUO, msalu_pkg::OP_REM: state_d = stat_i.b_zero ? S_LEN : S_DIV;
                msalu_pkg::OP_SHL: state_d = stat_i.cnt_big ? S_LEN : S_SHL;
                msalu_pkg::OP_SHR: begin
                  state_d = stat_i.cnt_big ? S_LEN : S_SHR;
                  k_d     = msalu_pkg::IDX_W'(msalu_pkg::WORD_COUNT - 1);
                end
                default: dp_cmd_o.clear = 1'b0;
              endcase
            end
            default: ;
          endcase
        end
      end
      S_AS: begin
        dp_cmd_o.as_step = 1'b1;
        if (32'(k_q) == msalu_pkg::WORD_COUNT - 1) begin
          k_d     = '0;
          state_d = S_AS_CHK;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_AS_CHK: begin
        // A borrow out of the first pass means |B| > |A|: redo as B - A
        if (!swap_q && !stat_i.same_sign && stat_i.carry) begin
          swap_d             = 1'b1;
          dp_cmd_o.carry_clr = 1'b1;
          state_d            = S_AS;
        end else begin
          dp_cmd_o.as_fin = 1'b1;
          state_d         = S_LEN;
        end
      end
      S_MUL: begin
        dp_cmd_o.mul_issue = 1'b1;
        dp_cmd_o.mul_last  = (i_q == hi);
        if (i_q == hi) begin
          if (32'(k_q) == 2 * msalu_pkg::WORD_COUNT - 2) begin
            state_d = S_MUL_DRAIN;
          end else begin
            k_d = k_q + 1'b1;
            i_d = lo_next;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_MUL_DRAIN: state_d = S_MUL_FIN;
      S_MUL_FIN: begin
        dp_cmd_o.mul_fin = 1'b1;
        state_d          = S_LEN;
      end
      S_DIV: begin
        dp_cmd_o.div_step = 1'b1;
        if (bit_q == '0) begin
          state_d = (op_q == msalu_pkg::OP_REM) ? S_REM : S_LEN;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      S_REM: begin
        dp_cmd_o.rem_copy = 1'b1;
        state_d           = S_LEN;
      end
      S_SHL: begin
        dp_cmd_o.shl_step = 1'b1;
        if (32'(k_q) == 2 * msalu_pkg::WORD_COUNT - 1) begin
          state_d = S_LEN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_SHR: begin
        dp_cmd_o.shr_step = 1'b1;
        if (k_q == '0) begin
          state_d = S_LEN;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      S_LEN: begin
        dp_cmd_o.len_cap = 1'b1;
        k_d              = '0;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        dp_cmd_o.emit      = 1'b1;
        dp_cmd_o.emit_last = (32'(k_q) == 32'(n_words) - 1);
        if (32'(k_q) == 32'(n_words) - 1) begin
          state_d = S_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= '0;
      k_q     <= '0;
      i_q     <= '0;
      bit_q   <= '0;
      swap_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      k_q     <= k_d;
      i_q     <= i_d;
      bit_q   <= bit_d;
      swap_q  <= swap_d;
    end
  end

endmodule

>>> rtl/multiword_signed_integer_alu_unit.sv
// Top level of the multiword sign-magnitude ALU: controller plus datapath.
//
// Operands A and B hold 20 words of 32 bits plus a sign each. A load (start with busy low)
// writes one word and the operand sign and keeps busy low. An execute
// raises busy until its last word is out; the result words then leave low first, one word
// per cycle, each shown for one cycle under strobe_o, and the receiver cannot hold them off.
// Each execute emits max(1, result length) words. Multiply uses one 32x32 multiplier, one partial
// product a cycle over all 400 word pairs; quotient and remainder take one quotient bit a cycle
// through a full-width trial subtract, and remainder then copies the remainder into the result;
// an add or subtract of unlike signs whose first pass borrows runs a second pass as B - A; and a
// zero divisor or an oversized shift count goes straight to the length step and emission.
module multiword_signed_integer_alu_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [2:0]  op_i,
  input  logic [4:0]  word_index_i,
  input  logic [31:0] word_value_i,
  input  logic        sign_i,
  output logic        strobe_o,
  output logic [4:0]  out_index_o,
  output logic [31:0] out_word_o,
  output logic        result_sign_o,
  output logic [4:0]  result_length_o,
  output logic        last_o,
  output logic        overflow_o,
  output logic        divide_by_zero_o
);

  msalu_pkg::dp_cmd_t  dp_cmd;
  msalu_pkg::dp_stat_t dp_stat;

  msalu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .op_i     (op_i),
    .stat_i   (dp_stat),
    .dp_cmd_o (dp_cmd),
    .busy     (busy)
  );

  msalu_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .word_index_i     (word_index_i),
    .word_value_i     (word_value_i),
    .sign_i           (sign_i),
    .stat_o           (dp_stat),
    .strobe_o         (strobe_o),
    .out_index_o      (out_index_o),
    .out_word_o       (out_word_o),
    .result_sign_o    (result_sign_o),
    .result_length_o  (result_length_o),
    .last_o           (last_o),
    .overflow_o       (overflow_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

endmodule

>>> rtl/msalu_props.sv
// Port-level properties of the multiword ALU and their binding to the top level.
module msalu_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        strobe_o,
  input logic [4:0]  out_index_o,
  input logic [31:0] out_word_o,
  input logic        result_sign_o,
  input logic [4:0]  result_length_o,
  input logic        last_o,
  input logic        overflow_o,
  input logic        divide_by_zero_o
);

  // A word stream ends with its last word; nothing follows at once
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("word directly after last word");

  // Words of one result come back to back with rising index
  a_words_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o && (out_index_o == 5'($past(out_index_o) + 5'd1)))
    else $error("result words not consecutive");

  a_last_matches_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |->
      (result_length_o == 5'(out_index_o + 5'd1)) ||
      ((result_length_o == 5'd0) && (out_index_o == 5'd0)))
    else $error("last word disagrees with result length");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (result_length_o == 5'd0) |-> (out_word_o == 32'd0) && !result_sign_o)
    else $error("zero result carries a value or a sign");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !(overflow_o && divide_by_zero_o))
    else $error("overflow and divide by zero together");

endmodule

bind multiword_signed_integer_alu_unit msalu_props u_msalu_props (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .strobe_o         (strobe_o),
  .out_index_o      (out_index_o),
  .out_word_o       (out_word_o),
  .result_sign_o    (result_sign_o),
  .result_length_o  (result_length_o),
  .last_o           (last_o),
  .overflow_o       (overflow_o),
  .divide_by_zero_o (divide_by_zero_o)
);

>>> bench/alu_result_checker.sv
// Result checker: mirrors the multiword ALU, predicts emitted words and compares them.
`timescale 1ns / 100ps
module alu_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [2:0]  op_i,
  input  logic [4:0]  word_index_i,
  input  logic [31:0] word_value_i,
  input  logic        sign_i,
  input  logic        strobe_o,
  input  logic [4:0]  out_index_o,
  input  logic [31:0] out_word_o,
  input  logic        result_sign_o,
  input  logic [4:0]  result_length_o,
  input  logic        last_o,
  input  logic        overflow_o,
  input  logic        divide_by_zero_o,
  output int          fail_count,
  output int          words_pending
);

  typedef struct packed {
    logic [4:0]  index;
    logic [31:0] value;
    logic        neg;
    logic [4:0]  length;
    logic        last;
    logic        ovf;
    logic        dz;
  } alu_word_t;

  alu_word_t expected_words[$];
  logic [msalu_pkg::MAG_W-1:0] mag_a, mag_b;
  logic sign_a, sign_b;

  assign words_pending = expected_words.size();

  // Compute one execute in wide arithmetic and queue the words it emits.
  task automatic predict_execute(input logic [2:0] op);
    logic [2*msalu_pkg::MAG_W:0] wide;
    logic [msalu_pkg::MAG_W-1:0] res;
    logic neg, ovf, dz, bneg;
    int len, n;
    logic [31:0] cnt;
    alu_word_t w;
    wide = '0; neg = 0; ovf = 0; dz = 0;
    case (op)
      msalu_pkg::OP_ADD, msalu_pkg::OP_SUB: begin
        bneg = sign_b ^ (op == msalu_pkg::OP_SUB);
        if (sign_a == bneg) begin
          wide = mag_a + mag_b; neg = bneg; ovf = wide[msalu_pkg::MAG_W];
        end else if (mag_a >= mag_b) begin
          wide = mag_a - mag_b; neg = sign_a;
        end else begin
          wide = mag_b - mag_a; neg = bneg;
        end
      end
      msalu_pkg::OP_MUL: begin
        wide = {{msalu_pkg::MAG_W{1'b0}}, mag_a} * {{msalu_pkg::MAG_W{1'b0}}, mag_b};
        ovf = |wide[2*msalu_pkg::MAG_W-1:msalu_pkg::MAG_W];
        neg = sign_a ^ sign_b;
      end
      msalu_pkg::OP_QUO, msalu_pkg::OP_REM: begin
        if (mag_b == '0) dz = 1;
        else begin
          wide = (op == msalu_pkg::OP_QUO) ? mag_a / mag_b : mag_a % mag_b;
          neg = (op == msalu_pkg::OP_QUO) ? sign_a ^ sign_b : sign_a;
        end
      end
      default: begin
        cnt = mag_b[31:0];
        neg = sign_a;
        if (cnt >= msalu_pkg::MAG_W) begin
          if (op == msalu_pkg::OP_SHL && mag_a != '0) ovf = 1;
        end else if (op == msalu_pkg::OP_SHL) begin
          wide = {{(msalu_pkg::MAG_W+1){1'b0}}, mag_a} << cnt;
          ovf = |wide[2*msalu_pkg::MAG_W:msalu_pkg::MAG_W];
        end else wide = mag_a >> cnt;
      end
    endcase
    res = wide[msalu_pkg::MAG_W-1:0];
    len = 0;
    for (int k = 0; k < msalu_pkg::WORD_COUNT; k++) if (res[k*32 +: 32] != 0) len = k + 1;
    if (len == 0) neg = 0;
    n = (len == 0) ? 1 : len;
    for (int k = 0; k < n; k++) begin
      w.index = k[4:0]; w.value = res[k*32 +: 32]; w.neg = neg;
      w.length = len[4:0]; w.last = (k == n - 1); w.ovf = ovf; w.dz = dz;
      expected_words.push_back(w);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alu_word_t got, exp_w;
    if (!rst_ni) begin
      mag_a <= '0; mag_b <= '0; sign_a <= 0; sign_b <= 0;
      fail_count <= 0;
      expected_words.delete();
    end else begin
      // Check an emitted word before queueing anything new from this edge.
      if (strobe_o) begin
        got = '{out_index_o, out_word_o, result_sign_o, result_length_o,
                last_o, overflow_o, divide_by_zero_o};
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (got !== exp_w) begin
            if (fail_count < 10)
              $display("mismatch: expected %h actual %h", exp_w, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        case (cmd_i)
          msalu_pkg::CMD_LOAD_A: begin
            if (word_index_i < msalu_pkg::WORD_COUNT)
              mag_a[word_index_i*32 +: 32] <= word_value_i;
            sign_a <= sign_i;
          end
          msalu_pkg::CMD_LOAD_B: begin
            if (word_index_i < msalu_pkg::WORD_COUNT)
              mag_b[word_index_i*32 +: 32] <= word_value_i;
            sign_b <= sign_i;
          end
          msalu_pkg::CMD_EXEC: if (op_i <= msalu_pkg::OP_SHR) predict_execute(op_i);
          default: ;
        endcase
      end
    end
  end

endmodule

>>> bench/testbench.sv
// Testbench top: drives load and execute words into the multiword ALU and reports the verdict.
`timescale 1ns / 100ps
module testbench;

  logic        clk_i = 0, rst_ni = 0, start = 0;
  logic        busy, strobe_o, result_sign_o, last_o, overflow_o, divide_by_zero_o;
  logic [1:0]  cmd_i = 0;
  logic [2:0]  op_i = 0;
  logic [4:0]  word_index_i = 0, out_index_o, result_length_o;
  logic [31:0] word_value_i = 0, out_word_o;
  logic        sign_i = 0;
  int          fail_count, words_pending;
  int          idle_pct;
  int          quiet_cycles = 0;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  multiword_signed_integer_alu_unit dut (.*);
  alu_result_checker checker_i (.*);

  // Watchdog: count cycles with no accepted word of either kind.
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Enter and leave at a falling edge; start stays high into the next word.
  task automatic send_word(input logic [1:0] c, input logic [2:0] o, input logic [4:0] idx,
                           input logic [31:0] val, input logic s);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk_i);
    end
    start <= 1; cmd_i <= c; op_i <= o; word_index_i <= idx;
    word_value_i <= val; sign_i <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Load every word of an operand: the given number of low words random, the rest zero.
  task automatic load_operand(input logic [1:0] c, input int words);
    for (int k = 0; k < msalu_pkg::WORD_COUNT; k++)
      send_word(c, 0, k[4:0], (k < words) ? $urandom() : 32'h0, 1'($urandom_range(1)));
  endtask

  initial begin
    idle_pct = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // Directed: zero operands, every op incl. zero divisor and zero result.
    for (int o = 0; o <= 7; o++) send_word(msalu_pkg::CMD_EXEC, o[2:0], 0, 0, 0);
    send_word(msalu_pkg::CMD_LOAD_A, 0, 19, 32'hFFFFFFFF, 1);
    send_word(msalu_pkg::CMD_LOAD_A, 0, 0, 32'hFFFFFFFF, 1);
    send_word(msalu_pkg::CMD_LOAD_B, 0, 0, 32'd1, 0);
    for (int o = 0; o <= 6; o++) send_word(msalu_pkg::CMD_EXEC, o[2:0], 0, 0, 0);
    send_word(msalu_pkg::CMD_LOAD_B, 0, 0, 32'd640, 1);   // oversized shift count
    send_word(msalu_pkg::CMD_EXEC, msalu_pkg::OP_SHL, 0, 0, 0);
    send_word(msalu_pkg::CMD_EXEC, msalu_pkg::OP_SHR, 0, 0, 0);
    send_word(msalu_pkg::CMD_LOAD_B, 0, 31, 32'h12345678, 0); // index out of range: sign only
    send_word(msalu_pkg::CMD_LOAD_B, 0, 0, 32'd639, 0);
    send_word(msalu_pkg::CMD_EXEC, msalu_pkg::OP_SHL, 0, 0, 0);
    send_word(3, 0, 0, 0, 0);
    // Random phases with varying sender idling.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 79 : (ph == 3) ? 34 : 0;
      for (int it = 0; it < 7; it++) begin
        if ($urandom_range(3) == 0) load_operand(msalu_pkg::CMD_LOAD_A, $urandom_range(1, 20));
        else for (int k = 0; k < 3; k++)
          send_word(msalu_pkg::CMD_LOAD_A, 0, 5'($urandom_range(0, 3)), $urandom(),
                    1'($urandom_range(1)));
        if ($urandom_range(2) == 0)
          send_word(msalu_pkg::CMD_LOAD_B, 0, 0, $urandom_range(0, 700),
                    1'($urandom_range(1)));
        else for (int k = 0; k < 2; k++)
          send_word(msalu_pkg::CMD_LOAD_B, 0, 5'($urandom_range(0, 31)), $urandom(),
                    1'($urandom_range(1)));
        for (int k = 0; k < 2; k++)
          send_word(($urandom_range(3) == 0) ? 2'($urandom_range(3)) : msalu_pkg::CMD_EXEC,
                    3'($urandom_range(7)), 5'($urandom_range(31)), $urandom(),
                    1'($urandom_range(1)));
        send_word(msalu_pkg::CMD_EXEC, 3'($urandom_range(6)), 0, 0, 0);
      end
    end
    start <= 0;
    while (words_pending != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
